@@ hw/rtl/bbme_pkg.sv @@
// Shared types and codes for the bus bridge mailbox engine.
package bbme_pkg;

  typedef enum logic [1:0] {
    ACT_BUS_WRITE = 2'd0,
    ACT_BUS_READ  = 2'd1,
    ACT_PUSH      = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_RDATA   = 2'd2,
    KIND_INVALID = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } parse_e;

  typedef enum logic [1:0] {
    RS_NONE    = 2'd0,
    RS_ARMED   = 2'd1,
    RS_SENDING = 2'd2
  } resp_e;

  // controller sequence
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EXEC = 2'd2,
    ST_OUT  = 2'd3
  } ctrl_e;

  localparam logic [7:0] EMPTY_BYTE = 8'hFF;
  localparam logic [7:0] READ_FLAG  = 8'h80;
  localparam logic [7:0] DEV_MASK   = 8'h7F;

  typedef struct packed {
    logic load;   // capture input item, start state/table read
    logic exec;   // compute result and update state
  } cmd_t;

endpackage

@@ hw/rtl/bbme_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
module bbme_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bbme_pkg::cmd_t cmd_o
);
  import bbme_pkg::*;

  ctrl_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_READ: ;
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // a result is offered only after its item was executed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("result not offered after execute");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("second item taken while busy");
endmodule

@@ hw/rtl/bbme_dp.sv @@
// Datapath: parser and response state, per-device FIFO pointers, byte memory.
module bbme_dp #(
  parameter int DEVICES      = 8,
  parameter int FIFO_DEPTH   = 256,
  parameter int MAX_RESPONSE = 254
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bbme_pkg::cmd_t cmd_i,
  input  logic [16:0]    in_data_i,
  output logic [1:0]     out_kind_o,
  output logic           out_last_o,
  output logic [31:0]    out_data_o
);
  import bbme_pkg::*;

  localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int FW = PW + 1;
  localparam int MW = DW + PW;

  // captured item
  logic [1:0] act_q;
  logic [6:0] hdev_q;
  logic [7:0] din_q;

  // control state
  parse_e     phase_q, phase_d;
  logic [6:0] adev_q, adev_d;
  logic [7:0] pleft_q, pleft_d;
  resp_e      rphase_q, rphase_d;
  logic [6:0] rdev_q, rdev_d;
  logic [7:0] rleft_q, rleft_d;
  logic [31:0] uflow_q, uflow_d;

  logic [PW-1:0] head_q [DEVICES];
  logic [PW-1:0] tail_q [DEVICES];
  logic [FW-1:0] fill_q [DEVICES];

  // one slot region of 2**PW bytes per device
  logic [7:0] mem [DEVICES*(2**PW)];
  logic [7:0] rd_q;

  // result register
  kind_e      kind_q, kind_d;
  logic [6:0] odev_q, odev_d;
  logic [7:0] dout_q, dout_d;
  logic       last_q, last_d;
  logic       acc_q, acc_d;
  logic [8:0] ofill_q, ofill_d;

  // FIFO pointer commands
  logic pop_en, clr_en;

  assign out_kind_o = kind_q;
  assign out_last_o = last_q;
  assign out_data_o = {7'd0, ofill_q, acc_q, dout_q, odev_q};

  // memory read address chosen by the incoming item (armed response device for a bus read)
  logic [6:0]    ld_act_dev;
  logic [DW-1:0] rd_dev;
  always_comb begin
    ld_act_dev = (in_data_i[1:0] == ACT_BUS_READ) ? rdev_q : in_data_i[8:2];
    rd_dev     = ld_act_dev[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= in_data_i[1:0];
      hdev_q <= in_data_i[8:2];
      din_q  <= in_data_i[16:9];
      rd_q   <= mem[{rd_dev, tail_q[rd_dev]}];
    end
  end

  // decoded item fields
  logic [7:0]    bdev8;
  logic [6:0]    bdev;
  logic          valid_b, valid_h, valid_r;
  logic [DW-1:0] bi, hi, ri, ai;
  logic [FW-1:0] len;
  logic          push_ok;
  logic          wr_en;
  logic [MW-1:0] wr_addr;
  always_comb begin
    bdev8   = din_q & DEV_MASK;
    bdev    = bdev8[6:0];
    valid_b = 32'(bdev) < DEVICES;
    valid_h = 32'(hdev_q) < DEVICES;
    valid_r = 32'(rdev_q) < DEVICES;
    bi = bdev[DW-1:0];
    hi = hdev_q[DW-1:0];
    ri = rdev_q[DW-1:0];
    ai = adev_q[DW-1:0];
    len = (32'(fill_q[ri]) > MAX_RESPONSE) ? FW'(MAX_RESPONSE) : fill_q[ri];
    push_ok = act_q == ACT_PUSH && valid_h && 32'(fill_q[hi]) < FIFO_DEPTH;
    wr_en   = cmd_i.exec && push_ok;
    wr_addr = {hi, head_q[hi]};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= din_q;
  end

  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p);
    wrap = (32'(p) >= FIFO_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // execute: next parser, response and result values
  always_comb begin
    phase_d  = phase_q;
    adev_d   = adev_q;
    pleft_d  = pleft_q;
    rphase_d = rphase_q;
    rdev_d   = rdev_q;
    rleft_d  = rleft_q;
    uflow_d  = uflow_q;
    kind_d   = KIND_ACK;
    odev_d   = hdev_q;
    dout_d   = '0;
    last_d   = 1'b0;
    acc_d    = 1'b0;
    ofill_d  = '0;
    pop_en   = 1'b0;
    clr_en   = 1'b0;
    unique case (act_q)
      ACT_BUS_WRITE: begin
        unique case (phase_q)
          PH_LENGTH: begin
            pleft_d = din_q;
            phase_d = (din_q == 8'd0) ? PH_IDLE : PH_PAYLOAD;
            odev_d  = adev_q;
            ofill_d = 9'(fill_q[ai]);
          end
          PH_PAYLOAD: begin
            pleft_d = pleft_q - 8'd1;
            if (pleft_q <= 8'd1) phase_d = PH_IDLE;
            kind_d  = KIND_PAYLOAD;
            odev_d  = adev_q;
            dout_d  = din_q;
            last_d  = (pleft_q <= 8'd1);
            ofill_d = 9'(fill_q[ai]);
          end
          default: begin
            // device byte; abandons a response in its data phase
            odev_d = bdev;
            if (rphase_q == RS_SENDING) begin
              rphase_d = RS_NONE;
              rleft_d  = '0;
            end
            if (!valid_b) begin
              phase_d = PH_IDLE;
              kind_d  = KIND_INVALID;
            end else begin
              if ((din_q & READ_FLAG) != 8'd0) begin
                rphase_d = RS_ARMED;
                rdev_d   = bdev;
                rleft_d  = '0;
                phase_d  = PH_IDLE;
              end else begin
                adev_d  = bdev;
                phase_d = PH_LENGTH;
              end
              ofill_d = 9'(fill_q[bi]);
            end
          end
        endcase
      end
      ACT_BUS_READ: begin
        kind_d = KIND_RDATA;
        odev_d = rdev_q;
        dout_d = EMPTY_BYTE;
        if (!valid_r) begin
          rphase_d = RS_NONE;
        end else begin
          ofill_d = 9'(fill_q[ri]);
          if (rphase_q == RS_ARMED) begin
            dout_d = 8'(len);
            if (len == '0) begin
              uflow_d  = uflow_q + 32'd1;
              rphase_d = RS_NONE;
            end else begin
              rleft_d  = 8'(len);
              rphase_d = RS_SENDING;
            end
          end else if (rphase_q == RS_SENDING) begin
            if (fill_q[ri] != '0) begin
              dout_d  = rd_q;
              pop_en  = 1'b1;
              ofill_d = 9'(fill_q[ri] - 1'b1);
            end
            rleft_d = rleft_q - 8'd1;
            if (rleft_q == 8'd1) rphase_d = RS_NONE;
          end
        end
      end
      ACT_PUSH: begin
        if (!valid_h) kind_d = KIND_INVALID;
        else if (push_ok) begin
          acc_d   = 1'b1;
          ofill_d = 9'(fill_q[hi] + 1'b1);
        end else ofill_d = 9'(fill_q[hi]);
      end
      ACT_CLEAR: begin
        if (!valid_h) kind_d = KIND_INVALID;
        else clr_en = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      adev_q   <= '0;
      pleft_q  <= '0;
      rphase_q <= RS_NONE;
      rdev_q   <= '0;
      rleft_q  <= '0;
      uflow_q  <= '0;
      for (int i = 0; i < DEVICES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
      kind_q <= KIND_ACK; odev_q <= '0; dout_q <= '0;
      last_q <= 1'b0; acc_q <= 1'b0; ofill_q <= '0;
    end else if (cmd_i.exec) begin
      phase_q  <= phase_d;
      adev_q   <= adev_d;
      pleft_q  <= pleft_d;
      rphase_q <= rphase_d;
      rdev_q   <= rdev_d;
      rleft_q  <= rleft_d;
      uflow_q  <= uflow_d;
      kind_q   <= kind_d;
      odev_q   <= odev_d;
      dout_q   <= dout_d;
      last_q   <= last_d;
      acc_q    <= acc_d;
      ofill_q  <= ofill_d;
      // at most one pointer update per item
      if (clr_en) begin
        head_q[hi] <= '0;
        tail_q[hi] <= '0;
        fill_q[hi] <= '0;
      end else if (wr_en) begin
        head_q[hi] <= wrap(head_q[hi]);
        fill_q[hi] <= fill_q[hi] + 1'b1;
      end else if (pop_en) begin
        tail_q[ri] <= wrap(tail_q[ri]);
        fill_q[ri] <= fill_q[ri] - 1'b1;
      end
    end
  end

  // a payload byte is only produced from the payload phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && act_q == ACT_BUS_WRITE && phase_q == PH_PAYLOAD)
      |=> kind_q == KIND_PAYLOAD)
    else $error("payload byte misclassified");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && act_q == ACT_CLEAR && valid_h) |=> fill_q[$past(hi)] == '0)
    else $error("clear left bytes");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(acc_q) |-> kind_q == KIND_ACK)
    else $error("accepted push with wrong kind");
endmodule

@@ hw/rtl/bus_bridge_mailbox_engine_core.sv @@
// Top level of the bus bridge mailbox engine.
// CPU bus bytes are parsed into write commands (device byte, length, payload
// bytes handed to the device with a last mark) and read requests that arm a
// response drawn from one of DEVICES byte FIFOs filled by host pushes; every
// input transaction yields exactly one result transaction. One item is in
// flight at a time: it is accepted in the idle cycle, where the FIFO memory is
// also read (registered read port), a wait state follows, the execute edge
// updates the parser, response and FIFO pointer state and loads the result
// register, and the result is offered from the output state until it is taken.
// An item passes the states accept, wait, execute and offer in that order; the
// result is held in the offer state while the output stalls.
module bus_bridge_mailbox_engine_core #(
  parameter int DEVICES      = 8,
  parameter int FIFO_DEPTH   = 256,
  parameter int MAX_RESPONSE = 254
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // host_device[6:0], data_in[14:7]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_device[6:0], data_out[14:7],
                                     // push_accepted[15], fill_count[24:16]
  output logic [1:0]  m_axis_tuser,  // result_kind[1:0]
  output logic        m_axis_tlast   // payload_last
);
  import bbme_pkg::*;

  cmd_t cmd;

  bbme_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  bbme_dp #(.DEVICES(DEVICES), .FIFO_DEPTH(FIFO_DEPTH), .MAX_RESPONSE(MAX_RESPONSE)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .in_data_i ({s_axis_tdata[14:0], s_axis_tuser}),
    .out_kind_o(m_axis_tuser),
    .out_last_o(m_axis_tlast),
    .out_data_o(m_axis_tdata)
  );
endmodule
